@@ hdl/palette_rgb565_tile_reorder_core_defines.svh @@
// Assertion macros shared by the palette converter modules.
// Each macro expects the including module to have ports named clock and reset.
`ifndef PALETTE_RGB565_TILE_REORDER_CORE_DEFINES_SVH
`define PALETTE_RGB565_TILE_REORDER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRTR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRTR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/prtr_pkg.sv @@
// Shared types, constants and the color packing function for the palette converter.
// Has no dependencies; every module of the block but prtr_ram imports it.
package prtr_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 11;
   localparam int COLOUR_W      = 8;
   localparam int WORD_W        = 16;
   localparam int DEST_W        = 20;
   localparam int PALETTE_DEPTH = 256;
   localparam int QUEUE_DEPTH   = 4;

   typedef enum logic {
      CMD_PALETTE = 1'b0,
      CMD_PIXEL   = 1'b1
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_TILE_WIDTH   = 3'd2,
      CSR_TILE_HEIGHT  = 3'd3,
      CSR_TILING_ON    = 3'd4
   } csr_reg_type;

   // Control part of one queued word. The position counters travel beside it.
   typedef struct packed {
      cmd_type               cmd;
      logic [COLOUR_W-1:0]   addr;
      logic [WORD_W-1:0]     word;
      logic                  frame_done;
   } job_ctl_type;

   // Cut the components to 5/6/5 bits, pack red on top and swap the two bytes.
   function automatic logic [WORD_W-1:0] pack_swapped(input logic [COLOUR_W-1:0] red,
                                                      input logic [COLOUR_W-1:0] green,
                                                      input logic [COLOUR_W-1:0] blue);
      logic [WORD_W-1:0] packed_word;
      packed_word = {red[7:3], green[7:2], blue[7:3]};
      return {packed_word[7:0], packed_word[15:8]};
   endfunction

endpackage

@@ hdl/prtr_ram.sv @@
// Generic single-port RAM with a registered read port.
// Depends on nothing; used for the color table.
module prtr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             en,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read data only changes on a read, so it holds while the consumer stalls.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/prtr_fifo.sv @@
// Small register queue between the front and back halves of the converter.
// Depends on the shared package and the assertion macro header.
`include "palette_rgb565_tile_reorder_core_defines.svh"
module prtr_fifo import prtr_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH,
   localparam int PW = $clog2(DEPTH),
   localparam int NW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == NW'(DEPTH));

   `PRTR_ASSERT_NOW(a_fifo_no_overflow, push, !full, "queue written while full")
   `PRTR_ASSERT_NOW(a_fifo_no_underflow, pop, !empty, "queue read while empty")

endmodule

@@ hdl/prtr_front.sv @@
// Front half: accepts words, packs palette colors and tracks the output position.
// Depends on the shared package and the assertion macro header.
`include "palette_rgb565_tile_reorder_core_defines.svh"
module prtr_front import prtr_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   localparam int CW   = $clog2(MAX_WIDTH),
   localparam int RW   = $clog2(MAX_HEIGHT),
   localparam int CWW  = $clog2(MAX_WIDTH + 1),
   localparam int CHW  = $clog2(MAX_HEIGHT + 1),
   localparam int CNTW = $clog2(RW)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic [COLOUR_W-1:0] req_entry_number,
   input  logic [COLOUR_W-1:0] req_red,
   input  logic [COLOUR_W-1:0] req_green,
   input  logic [COLOUR_W-1:0] req_blue,
   input  logic [COLOUR_W-1:0] req_colour_index,
   input  logic [CWW-1:0]      w_size,
   input  logic [CHW-1:0]      h_size,
   input  logic [CWW-1:0]      tw_size,
   input  logic [CHW-1:0]      th_size,
   input  logic                rows_stale,
   input  logic                queue_full,
   output logic                push,
   output job_ctl_type         job_ctl,
   output logic [CW-1:0]       job_col,
   output logic [CW-1:0]       job_itc,
   output logic [CW-1:0]       job_tc,
   output logic [RW-1:0]       job_row,
   output logic [RW-1:0]       job_itr,
   output logic [RW-1:0]       job_tr
);

   logic             frame_start_ff, frame_start_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [CW-1:0]    itc_ff, itc_in;
   logic [CW-1:0]    tc_ff, tc_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [RW-1:0]    itr_ff, itr_in;
   logic [RW-1:0]    tr_ff, tr_in;

   logic             div_pending_ff, div_pending_in;
   logic             div_busy_ff, div_busy_in;
   logic             rows_ready_ff, rows_ready_in;
   logic [RW-1:0]    div_rem_ff, div_rem_in;
   logic [RW-1:0]    div_quo_ff, div_quo_in;
   logic [CNTW-1:0]  div_cnt_ff, div_cnt_in;
   logic [RW:0]      div_trial;
   logic             div_take;

   logic             is_pixel;
   logic             accept_pixel;
   logic [CW-1:0]    cur_col, cur_itc, cur_tc;
   logic [RW-1:0]    cur_row, cur_itr, cur_tr;
   logic             row_end, tile_col_end, last_pixel;

   assign is_pixel     = (cmd_type'(req_cmd) == CMD_PIXEL);
   assign req_stall    = queue_full || (is_pixel && frame_start_ff && !rows_ready_ff);
   assign push         = req_valid && !req_stall;
   assign accept_pixel = push && is_pixel;

   // Row divider: splits the bottom output row into tile row and row within the tile,
   // one quotient bit per cycle. It reruns whenever a height register is written.
   always_comb begin
      div_pending_in = div_pending_ff;
      div_busy_in    = div_busy_ff;
      rows_ready_in  = rows_ready_ff;
      div_rem_in     = div_rem_ff;
      div_quo_in     = div_quo_ff;
      div_cnt_in     = div_cnt_ff;
      div_trial      = {div_rem_ff, div_quo_ff[RW-1]};
      div_take       = (div_trial >= (RW+1)'(th_size));
      if (rows_stale) begin
         div_pending_in = 1'b1;
         div_busy_in    = 1'b0;
         rows_ready_in  = 1'b0;
      end else if (div_pending_ff) begin
         div_pending_in = 1'b0;
         div_busy_in    = 1'b1;
         div_rem_in     = '0;
         div_quo_in     = RW'(h_size - 1'b1);
         div_cnt_in     = CNTW'(RW - 1);
      end else if (div_busy_ff) begin
         div_rem_in = div_take ? RW'(div_trial - (RW+1)'(th_size)) : RW'(div_trial);
         div_quo_in = {div_quo_ff[RW-2:0], div_take};
         div_cnt_in = div_cnt_ff - 1'b1;
         if (div_cnt_ff == '0) begin
            div_busy_in   = 1'b0;
            rows_ready_in = 1'b1;
         end
      end
   end

   // Position counters. The first pixel of a frame starts from the reloaded values.
   always_comb begin
      cur_col = frame_start_ff ? '0 : col_ff;
      cur_itc = frame_start_ff ? '0 : itc_ff;
      cur_tc  = frame_start_ff ? '0 : tc_ff;
      cur_row = frame_start_ff ? RW'(h_size - 1'b1) : row_ff;
      cur_itr = frame_start_ff ? div_rem_ff : itr_ff;
      cur_tr  = frame_start_ff ? div_quo_ff : tr_ff;

      row_end      = (CWW'(cur_col) >= CWW'(w_size - 1'b1));
      tile_col_end = (CWW'(cur_itc) >= CWW'(tw_size - 1'b1));
      last_pixel   = row_end && (cur_row == '0);

      frame_start_in = frame_start_ff;
      col_in = col_ff;
      itc_in = itc_ff;
      tc_in  = tc_ff;
      row_in = row_ff;
      itr_in = itr_ff;
      tr_in  = tr_ff;

      if (accept_pixel) begin
         frame_start_in = last_pixel;
         row_in = cur_row;
         itr_in = cur_itr;
         tr_in  = cur_tr;
         if (row_end) begin
            col_in = '0;
            itc_in = '0;
            tc_in  = '0;
            if (cur_row != '0) begin
               row_in = cur_row - 1'b1;
               if (cur_itr == '0) begin
                  itr_in = RW'(th_size - 1'b1);
                  tr_in  = (cur_tr != '0) ? cur_tr - 1'b1 : cur_tr;
               end else begin
                  itr_in = cur_itr - 1'b1;
               end
            end
         end else begin
            col_in = cur_col + 1'b1;
            if (tile_col_end) begin
               itc_in = '0;
               tc_in  = cur_tc + 1'b1;
            end else begin
               itc_in = cur_itc + 1'b1;
               tc_in  = cur_tc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_start_ff <= 1'b1;
         col_ff         <= '0;
         itc_ff         <= '0;
         tc_ff          <= '0;
         row_ff         <= '0;
         itr_ff         <= '0;
         tr_ff          <= '0;
         div_pending_ff <= 1'b1;
         div_busy_ff    <= 1'b0;
         rows_ready_ff  <= 1'b0;
      end else begin
         frame_start_ff <= frame_start_in;
         col_ff         <= col_in;
         itc_ff         <= itc_in;
         tc_ff          <= tc_in;
         row_ff         <= row_in;
         itr_ff         <= itr_in;
         tr_ff          <= tr_in;
         div_pending_ff <= div_pending_in;
         div_busy_ff    <= div_busy_in;
         rows_ready_ff  <= rows_ready_in;
      end
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_cnt_ff <= div_cnt_in;
   end

   always_comb begin
      job_ctl.cmd        = cmd_type'(req_cmd);
      job_ctl.addr       = is_pixel ? req_colour_index : req_entry_number;
      job_ctl.word       = pack_swapped(req_red, req_green, req_blue);
      job_ctl.frame_done = is_pixel && last_pixel;
   end

   assign job_col = cur_col;
   assign job_itc = cur_itc;
   assign job_tc  = cur_tc;
   assign job_row = cur_row;
   assign job_itr = cur_itr;
   assign job_tr  = cur_tr;

   `PRTR_ASSERT_NOW(a_front_rows_ready, accept_pixel && frame_start_ff, rows_ready_ff, "frame started before the row split was ready")
   `PRTR_ASSERT_NEXT(a_front_frame_restart, push && job_ctl.frame_done, frame_start_ff, "last pixel did not rearm the frame start")

endmodule

@@ hdl/prtr_back.sv @@
// Back half: executes queued words, looks up colors and forms destination positions.
// Depends on the shared package and the generic RAM.
module prtr_back import prtr_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   localparam int CW  = $clog2(MAX_WIDTH),
   localparam int RW  = $clog2(MAX_HEIGHT),
   localparam int CWW = $clog2(MAX_WIDTH + 1),
   localparam int CHW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   output logic              pop,
   input  job_ctl_type       job_ctl,
   input  logic [CW-1:0]     job_col,
   input  logic [CW-1:0]     job_itc,
   input  logic [CW-1:0]     job_tc,
   input  logic [RW-1:0]     job_row,
   input  logic [RW-1:0]     job_itr,
   input  logic [RW-1:0]     job_tr,
   input  logic [CWW-1:0]    w_size,
   input  logic [CWW-1:0]    tw_size,
   input  logic [CHW-1:0]    th_size,
   input  logic              tiling_on,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DEST_W-1:0] rsp_dest_index,
   output logic [WORD_W-1:0] rsp_pixel_word,
   output logic              rsp_frame_done
);

   logic              advance;
   logic              ram_we;
   logic [WORD_W-1:0] ram_rdata;

   logic              s1_valid_ff;
   logic [DEST_W-1:0] s1_tile_row_ff, s1_tile_col_ff, s1_in_row_ff, s1_raster_ff;
   logic [CW-1:0]     s1_itc_ff, s1_col_ff;
   logic              s1_done_ff;

   logic              s2_valid_ff;
   logic [DEST_W-1:0] s2_tile_row_ff, s2_tile_col_ff, s2_in_tile_ff, s2_raster_ff;
   logic [WORD_W-1:0] s2_word_ff;
   logic              s2_done_ff;

   logic              rsp_valid_ff;
   logic [DEST_W-1:0] rsp_dest_ff, rsp_dest_in;
   logic [WORD_W-1:0] rsp_word_ff;
   logic              rsp_done_ff;

   // The whole pipeline moves together; it only holds while a result waits.
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && !queue_empty;
   assign ram_we  = (job_ctl.cmd == CMD_PALETTE);

   prtr_ram #(
      .WIDTH(WORD_W),
      .DEPTH(PALETTE_DEPTH)
   ) u_colour_table (
      .clock(clock),
      .en   (pop),
      .we   (ram_we),
      .addr (job_ctl.addr),
      .wdata(job_ctl.word),
      .rdata(ram_rdata)
   );

   assign rsp_dest_in = tiling_on ? (s2_tile_row_ff + s2_tile_col_ff + s2_in_tile_ff)
                                  : s2_raster_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= pop && !ram_we;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         // First products, all reduced to the 20-bit position space.
         s1_tile_row_ff <= DEST_W'(job_tr) * DEST_W'(th_size);
         s1_tile_col_ff <= DEST_W'(job_tc) * DEST_W'(tw_size);
         s1_in_row_ff   <= DEST_W'(job_itr) * DEST_W'(tw_size);
         s1_raster_ff   <= DEST_W'(job_row) * DEST_W'(w_size);
         s1_itc_ff      <= job_itc;
         s1_col_ff      <= job_col;
         s1_done_ff     <= job_ctl.frame_done;

         s2_tile_row_ff <= s1_tile_row_ff * DEST_W'(w_size);
         s2_tile_col_ff <= s1_tile_col_ff * DEST_W'(th_size);
         s2_in_tile_ff  <= s1_in_row_ff + DEST_W'(s1_itc_ff);
         s2_raster_ff   <= s1_raster_ff + DEST_W'(s1_col_ff);
         s2_word_ff     <= ram_rdata;
         s2_done_ff     <= s1_done_ff;

         rsp_dest_ff <= rsp_dest_in;
         rsp_word_ff <= s2_word_ff;
         rsp_done_ff <= s2_done_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dest_index = rsp_dest_ff;
   assign rsp_pixel_word = rsp_word_ff;
   assign rsp_frame_done = rsp_done_ff;

endmodule

@@ hdl/palette_rgb565_tile_reorder_core.sv @@
// Indexed-color to byte-swapped RGB565 converter with vertical flip and tile reorder.
// The request channel carries palette writes (cmd 0) and pixel indexes (cmd 1);
// each pixel yields one response word with its destination index and color.
// Palette writes yield no response. Registers are written over the csr port.
// An accepted pixel passes the queue and then the s1, s2 and response registers
// on its way out, and the block takes one word per cycle from one frame start to
// the next while the queue is not full. The first pixel of a frame waits while the
// row divider splits the bottom row into tile row and row within a tile; it runs
// after reset and after every write to the image or tile height register. Palette
// words pass during that time. A four-word queue separates the request side from
// the lookup pipeline, so a response stall fills the queue first and reaches
// req_stall only when it is full. Reset clears the registers to a 1x1 raster
// image, arms the frame start and empties the pipeline; the color table is not
// cleared and an entry must be written before a pixel uses it.
// Depends on prtr_pkg, prtr_front, prtr_fifo, prtr_back and prtr_ram.
module palette_rgb565_tile_reorder_core import prtr_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_cmd,
   input  logic [COLOUR_W-1:0]    req_entry_number,
   input  logic [COLOUR_W-1:0]    req_red,
   input  logic [COLOUR_W-1:0]    req_green,
   input  logic [COLOUR_W-1:0]    req_blue,
   input  logic [COLOUR_W-1:0]    req_colour_index,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [DEST_W-1:0]      rsp_dest_index,
   output logic [WORD_W-1:0]      rsp_pixel_word,
   output logic                   rsp_frame_done,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int CWW   = $clog2(MAX_WIDTH + 1);
   localparam int CHW   = $clog2(MAX_HEIGHT + 1);
   localparam int JOB_W = $bits(job_ctl_type) + 3 * CW + 3 * RW;

   logic [CSR_DATA_W-1:0] image_width_ff, image_width_in;
   logic [CSR_DATA_W-1:0] image_height_ff, image_height_in;
   logic [CSR_DATA_W-1:0] tile_width_ff, tile_width_in;
   logic [CSR_DATA_W-1:0] tile_height_ff, tile_height_in;
   logic                  tiling_on_ff, tiling_on_in;

   logic [CWW-1:0] w_size, tw_size;
   logic [CHW-1:0] h_size, th_size;
   logic           rows_stale;

   logic           push, pop, queue_empty, queue_full;
   job_ctl_type    front_ctl, back_ctl;
   logic [CW-1:0]  front_col, front_itc, front_tc, back_col, back_itc, back_tc;
   logic [RW-1:0]  front_row, front_itr, front_tr, back_row, back_itr, back_tr;
   logic [JOB_W-1:0] queue_wdata, queue_rdata;

   // Register writes. Indexes beyond the list are ignored.
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      tile_width_in   = tile_width_ff;
      tile_height_in  = tile_height_ff;
      tiling_on_in    = tiling_on_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: image_height_in = csr_wdata;
            CSR_TILE_WIDTH:   tile_width_in   = csr_wdata;
            CSR_TILE_HEIGHT:  tile_height_in  = csr_wdata;
            CSR_TILING_ON:    tiling_on_in    = csr_wdata[0];
            default:          tiling_on_in    = tiling_on_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= CSR_DATA_W'(1);
         image_height_ff <= CSR_DATA_W'(1);
         tile_width_ff   <= CSR_DATA_W'(1);
         tile_height_ff  <= CSR_DATA_W'(1);
         tiling_on_ff    <= 1'b0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         tile_width_ff   <= tile_width_in;
         tile_height_ff  <= tile_height_in;
         tiling_on_ff    <= tiling_on_in;
      end
   end

   // A size of zero counts as one, and sizes are capped at the configured limits.
   always_comb begin
      if (image_width_ff == '0) begin
         w_size = CWW'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         w_size = CWW'(MAX_WIDTH);
      end else begin
         w_size = CWW'(image_width_ff);
      end
      if (tile_width_ff == '0) begin
         tw_size = CWW'(1);
      end else if (32'(tile_width_ff) > MAX_WIDTH) begin
         tw_size = CWW'(MAX_WIDTH);
      end else begin
         tw_size = CWW'(tile_width_ff);
      end
      if (image_height_ff == '0) begin
         h_size = CHW'(1);
      end else if (32'(image_height_ff) > MAX_HEIGHT) begin
         h_size = CHW'(MAX_HEIGHT);
      end else begin
         h_size = CHW'(image_height_ff);
      end
      if (tile_height_ff == '0) begin
         th_size = CHW'(1);
      end else if (32'(tile_height_ff) > MAX_HEIGHT) begin
         th_size = CHW'(MAX_HEIGHT);
      end else begin
         th_size = CHW'(tile_height_ff);
      end
   end

   // The row split for the next frame start must be recomputed after a height change.
   assign rows_stale = csr_we && ((csr_index == CSR_IMAGE_HEIGHT) ||
                                  (csr_index == CSR_TILE_HEIGHT));

   prtr_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_entry_number(req_entry_number),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_colour_index(req_colour_index),
      .w_size          (w_size),
      .h_size          (h_size),
      .tw_size         (tw_size),
      .th_size         (th_size),
      .rows_stale      (rows_stale),
      .queue_full      (queue_full),
      .push            (push),
      .job_ctl         (front_ctl),
      .job_col         (front_col),
      .job_itc         (front_itc),
      .job_tc          (front_tc),
      .job_row         (front_row),
      .job_itr         (front_itr),
      .job_tr          (front_tr)
   );

   assign queue_wdata = {front_ctl, front_col, front_itc, front_tc,
                         front_row, front_itr, front_tr};

   prtr_fifo #(
      .WIDTH(JOB_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(queue_wdata),
      .pop      (pop),
      .pop_data (queue_rdata),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   assign {back_ctl, back_col, back_itc, back_tc, back_row, back_itr, back_tr} = queue_rdata;

   prtr_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .pop           (pop),
      .job_ctl       (back_ctl),
      .job_col       (back_col),
      .job_itc       (back_itc),
      .job_tc        (back_tc),
      .job_row       (back_row),
      .job_itr       (back_itr),
      .job_tr        (back_tr),
      .w_size        (w_size),
      .tw_size       (tw_size),
      .th_size       (th_size),
      .tiling_on     (tiling_on_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_dest_index(rsp_dest_index),
      .rsp_pixel_word(rsp_pixel_word),
      .rsp_frame_done(rsp_frame_done)
   );

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for palette_rgb565_tile_reorder_core: palette writes and pixel words
// go in with random gaps and stalls, and every response is checked against an in-bench
// model of the color lookup and the flip/tile addressing. Depends on prtr_pkg and the RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import prtr_pkg::*;

   // Cycles to let pass after the last expected response, so that palette words still
   // in the queue or the lookup pipeline have landed before a register changes.
   localparam int unsigned DRAIN_CYCLES = 10;
   // Cycles with no handshake at all before the run is declared hung.
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned MAX_REPORTS  = 10;

   // One expected response word.
   typedef struct {
      logic [DEST_W-1:0] dest;
      logic [WORD_W-1:0] word;
      logic              done;
   } pixel_result_type;

   // ---------------------------------------------------------------------------------
   // Block ports. Every input starts at a known value.
   // ---------------------------------------------------------------------------------
   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   cmd_type                req_cmd          = CMD_PALETTE;
   logic [COLOUR_W-1:0]    req_entry_number = '0;
   logic [COLOUR_W-1:0]    req_red          = '0;
   logic [COLOUR_W-1:0]    req_green        = '0;
   logic [COLOUR_W-1:0]    req_blue         = '0;
   logic [COLOUR_W-1:0]    req_colour_index = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [DEST_W-1:0]      rsp_dest_index;
   logic [WORD_W-1:0]      rsp_pixel_word;
   logic                   rsp_frame_done;
   logic                   csr_we           = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata        = '0;

   palette_rgb565_tile_reorder_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_entry_number (req_entry_number),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_colour_index (req_colour_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dest_index   (rsp_dest_index),
      .rsp_pixel_word   (rsp_pixel_word),
      .rsp_frame_done   (rsp_frame_done),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Model of the block: register copies, the color table and the position counters.
   // ---------------------------------------------------------------------------------
   logic [CSR_DATA_W-1:0] img_w_reg, img_h_reg, tile_w_reg, tile_h_reg;
   logic                  tiling_reg;
   logic [WORD_W-1:0]     colour_table_copy [PALETTE_DEPTH];
   bit                    entry_written [PALETTE_DEPTH];
   // Entries written so far; pixels only ever point at one of these, since a read of a
   // never-written entry has no defined result.
   logic [COLOUR_W-1:0]   written_entries [$];
   int unsigned           col_pos, out_row, in_tile_col, tile_col, in_tile_row, tile_row;
   bit                    frame_armed;
   bit                    frame_closed;
   pixel_result_type      pending_pixels [$];

   int unsigned           words_sent;
   int unsigned           fail_count;
   int unsigned           quiet_cycles;
   int unsigned           send_gap_pct;
   int unsigned           rsp_hold_pct;

   // A size register of zero acts as one, and anything above the limit acts as the limit.
   function automatic int unsigned clamp_dim(logic [CSR_DATA_W-1:0] v, int unsigned cap);
      if (v == 0) return 1;
      if (v > cap) return cap;
      return 32'(v);
   endfunction

   // The bottom row of the file is the top row of the output, so the row count starts
   // at the last row and is split into tile row and row within the tile.
   function automatic void load_row_counters();
      int unsigned th;
      th          = clamp_dim(tile_h_reg, MAX_HEIGHT_DEF);
      out_row     = clamp_dim(img_h_reg, MAX_HEIGHT_DEF) - 1;
      in_tile_row = out_row % th;
      tile_row    = out_row / th;
   endfunction

   function automatic void reset_model();
      img_w_reg  = CSR_DATA_W'(1);
      img_h_reg  = CSR_DATA_W'(1);
      tile_w_reg = CSR_DATA_W'(1);
      tile_h_reg = CSR_DATA_W'(1);
      tiling_reg = 1'b0;
      foreach (entry_written[i]) entry_written[i] = 1'b0;
      written_entries.delete();
      col_pos     = 0;
      in_tile_col = 0;
      tile_col    = 0;
      load_row_counters();
      frame_armed = 1'b1;
   endfunction

   // A palette word keeps the top 5/6/5 bits of red, green and blue, packs red highest,
   // and stores the two bytes swapped.
   function automatic void store_entry(logic [7:0] entry, logic [7:0] red,
                                       logic [7:0] green, logic [7:0] blue);
      logic [WORD_W-1:0] rgb565;
      rgb565 = {red[7:3], green[7:2], blue[7:3]};
      colour_table_copy[entry] = {rgb565[7:0], rgb565[15:8]};
      if (!entry_written[entry]) begin
         entry_written[entry] = 1'b1;
         written_entries.push_back(entry);
      end
   endfunction

   // A pixel word: look up its color, work out where it lands in the output image and
   // advance the counters. The registers are read as they stand now; only the row
   // counters are latched, and only on the first pixel of a frame.
   function automatic void place_pixel(logic [7:0] colour_index);
      int unsigned      w, tw, th, dest;
      pixel_result_type res;
      if (frame_armed) begin
         col_pos     = 0;
         in_tile_col = 0;
         tile_col    = 0;
         load_row_counters();
         frame_armed = 1'b0;
      end
      w  = clamp_dim(img_w_reg, MAX_WIDTH_DEF);
      tw = clamp_dim(tile_w_reg, MAX_WIDTH_DEF);
      th = clamp_dim(tile_h_reg, MAX_HEIGHT_DEF);
      if (tiling_reg)
         dest = tile_row * th * w + tile_col * tw * th + in_tile_row * tw + in_tile_col;
      else
         dest = out_row * w + col_pos;
      // Uneven tiles or registers changed mid-frame can push the position past the
      // output range; the block keeps only the low bits.
      res.dest = dest[DEST_W-1:0];
      res.word = colour_table_copy[colour_index];
      res.done = 1'b0;
      // A row ends once the column reaches the current width, even if the width shrank
      // under it; the frame ends after output row zero.
      if (col_pos >= w - 1) begin
         col_pos     = 0;
         in_tile_col = 0;
         tile_col    = 0;
         if (out_row == 0) begin
            res.done    = 1'b1;
            frame_armed = 1'b1;
         end else begin
            out_row--;
            if (in_tile_row == 0) begin
               in_tile_row = th - 1;
               if (tile_row > 0) tile_row--;
            end else begin
               in_tile_row--;
            end
         end
      end else begin
         col_pos++;
         if (in_tile_col >= tw - 1) begin
            in_tile_col = 0;
            tile_col++;
         end else begin
            in_tile_col++;
         end
      end
      frame_closed = res.done;
      pending_pixels.push_back(res);
   endfunction

   function automatic logic [7:0] pick_written();
      return written_entries[$urandom_range(written_entries.size() - 1)];
   endfunction

   // Mostly a tile size that divides the image, sometimes anything up to a bit past it,
   // zero included.
   function automatic int unsigned pick_tile(int unsigned dim);
      int unsigned t;
      if ($urandom_range(9) == 0) return $urandom_range(dim + 2);
      do t = $urandom_range(1, dim); while (dim % t != 0);
      return t;
   endfunction

   function automatic void note_failure(string what);
      if (fail_count < MAX_REPORTS) $display("Mismatch at %0t ns: %s", $realtime, what);
      fail_count++;
   endfunction

   // ---------------------------------------------------------------------------------
   // Driving the block.
   // ---------------------------------------------------------------------------------

   // Send one request word. Random idle cycles come first; then the word is held until
   // the edge that takes it, and the model is updated at that edge. Valid is left high
   // so that back-to-back words never lower and raise it in the same step.
   task automatic send_word(cmd_type cmd, logic [7:0] entry, logic [7:0] red,
                            logic [7:0] green, logic [7:0] blue, logic [7:0] colour_index);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_entry_number <= entry;
      req_red          <= red;
      req_green        <= green;
      req_blue         <= blue;
      req_colour_index <= colour_index;
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (cmd == CMD_PALETTE)
         store_entry(entry, red, green, blue);
      else
         place_pixel(colour_index);
   endtask

   // Fields that a word kind does not use still carry random bits.
   task automatic send_palette(logic [7:0] entry, logic [7:0] red, logic [7:0] green,
                               logic [7:0] blue);
      send_word(CMD_PALETTE, entry, red, green, blue, 8'($urandom_range(255)));
   endtask

   task automatic send_pixel(logic [7:0] colour_index);
      send_word(CMD_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(255)), colour_index);
   endtask

   task automatic send_random_word();
      if (written_entries.size() == 0 || $urandom_range(99) < 20)
         send_palette(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
      else
         send_pixel(pick_written());
   endtask

   // Hold the sender off until every expected response is back, then give the pipeline
   // time to swallow any palette words behind the last pixel.
   task automatic drain_idle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write per edge; the enable stays high across a burst of writes.
   task automatic write_reg(csr_reg_type idx, int unsigned value);
      logic [CSR_DATA_W-1:0] v;
      v = value[CSR_DATA_W-1:0];
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         CSR_IMAGE_WIDTH:  img_w_reg  = v;
         CSR_IMAGE_HEIGHT: img_h_reg  = v;
         CSR_TILE_WIDTH:   tile_w_reg = v;
         CSR_TILE_HEIGHT:  tile_h_reg = v;
         CSR_TILING_ON:    tiling_reg = v[0];
         default: ;
      endcase
   endtask

   // Registers only change while the block is idle. The mask picks which ones to write.
   task automatic program_regs(int unsigned w, int unsigned h, int unsigned tw,
                               int unsigned th, int unsigned tiling, logic [4:0] which);
      drain_idle();
      if (which[CSR_IMAGE_WIDTH])  write_reg(CSR_IMAGE_WIDTH, w);
      if (which[CSR_IMAGE_HEIGHT]) write_reg(CSR_IMAGE_HEIGHT, h);
      if (which[CSR_TILE_WIDTH])   write_reg(CSR_TILE_WIDTH, tw);
      if (which[CSR_TILE_HEIGHT])  write_reg(CSR_TILE_HEIGHT, th);
      if (which[CSR_TILING_ON])    write_reg(CSR_TILING_ON, tiling);
      csr_we <= 1'b0;
   endtask

   // The receiver stalls at random, at the rate the current phase sets.
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < rsp_hold_pct);

   // ---------------------------------------------------------------------------------
   // Response checking: each accepted response word against the oldest expectation.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            note_failure($sformatf("response with nothing expected, dest_index %0d",
                                   rsp_dest_index));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_dest_index !== want.dest)
               note_failure($sformatf("dest_index expected %0d, got %0d",
                                      want.dest, rsp_dest_index));
            if (rsp_pixel_word !== want.word)
               note_failure($sformatf("pixel_word expected %h, got %h",
                                      want.word, rsp_pixel_word));
            if (rsp_frame_done !== want.done)
               note_failure($sformatf("frame_done expected %b, got %b",
                                      want.done, rsp_frame_done));
         end
      end
   end

   // Hang detection: count cycles in which nothing moves on any port.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------------

   // Palette extremes and truncation, read back through the reset configuration, which
   // is a 1x1 raster image: every pixel is a whole frame at position zero.
   task automatic test_palette_and_reset_pixel();
      send_palette(8'd0, 8'h00, 8'h00, 8'h00);
      send_palette(8'd255, 8'hFF, 8'hFF, 8'hFF);
      send_palette(8'd1, 8'hFF, 8'h00, 8'h00);
      send_palette(8'd2, 8'h00, 8'hFF, 8'h00);
      // Only the low bits of red and green are set, so they vanish; blue keeps its top.
      send_palette(8'd128, 8'h07, 8'h03, 8'hF8);
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd1);
      send_pixel(8'd2);
      send_pixel(8'd128);
   endtask

   // Tile order with a tile width that does not divide the image and a zero tile height.
   task automatic test_tiled_uneven();
      program_regs(3, 2, 2, 0, 1, 5'b11111);
      repeat (6) send_pixel(pick_written());
   endtask

   // Registers rewritten inside a frame. The frame starts as a 2x2 tiled image with
   // 1x1 tiles; then width and tile height go far over the limit, so the position
   // overflows the output range; then a zero width closes the row at once.
   task automatic test_mid_frame_limits();
      program_regs(2, 2, 1, 1, 1, 5'b11111);
      send_pixel(pick_written());
      program_regs(2047, 0, 0, 2047, 0, 5'b01001);
      send_pixel(pick_written());
      program_regs(0, 0, 0, 1, 0, 5'b01001);
      send_pixel(pick_written());
      send_pixel(pick_written());
   endtask

   // Whole frames of random shape with palette words mixed in. Now and then the width,
   // tile width or tiling changes in mid-frame, and now and then the sender simply
   // waits for the block to run dry.
   task automatic test_random_traffic(int unsigned word_budget);
      int unsigned stop_at, w, h, tw, th;
      stop_at = words_sent + word_budget;
      while (words_sent < stop_at) begin
         w  = $urandom_range(1, 16);
         h  = $urandom_range(1, 10);
         tw = pick_tile(w);
         th = pick_tile(h);
         if ($urandom_range(19) == 0) w = 0;
         if ($urandom_range(19) == 0) h = 0;
         // Only bit 0 of the tiling register counts; the rest is random.
         program_regs(w, h, tw, th, $urandom_range(2047), 5'b11111);
         frame_closed = 1'b0;
         while (!frame_closed) begin
            if (!frame_armed && $urandom_range(149) == 0)
               program_regs($urandom_range(1, 16), 0, $urandom_range(8), 0,
                            $urandom_range(2047), 5'b10101);
            else if ($urandom_range(79) == 0)
               drain_idle();
            send_random_word();
         end
      end
   endtask

   // Height over the limit acts as 1024 rows; a few pixels of the bottom row are enough
   // to see the clamped start row split by an uneven tile height.
   task automatic test_capped_height();
      program_regs(1, 2047, 1, 1000, 1, 5'b11111);
      repeat (4) send_pixel(pick_written());
   endtask

   initial begin
      reset_model();
      words_sent   = 0;
      fail_count   = 0;
      send_gap_pct = 8;
      rsp_hold_pct = 68;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_palette_and_reset_pixel();
      test_tiled_uneven();
      test_mid_frame_limits();
      // Mostly a slow receiver, then mostly a slow sender, then full rate.
      test_random_traffic(470);
      send_gap_pct = 68;
      rsp_hold_pct = 8;
      test_random_traffic(470);
      send_gap_pct = 0;
      rsp_hold_pct = 0;
      test_random_traffic(470);
      test_capped_height();

      drain_idle();
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
